### rtl/core/ldn_pkg.sv
// Shared types and constants for the 3x3 local divisive normalizer.
package ldn_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 16;
  localparam int CFG_W     = 11;
  localparam int IDX_W     = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  typedef struct packed {
    logic              action;
    logic signed [15:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normalized_value;
    logic              last_of_run;
    logic              end_of_frame;
  } out_item_t;

  // Window in row-major order, center at element 4.
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic                  last;
    logic                  eof;
  } job_t;

endpackage

### rtl/core/ldn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ldn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ldn_front.sv
// Front end: line stores, 3x3 window, raster counters and drain sequencing.
module ldn_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  ldn_pkg::in_item_t        in_data,
  input  logic [ldn_pkg::CFG_W-1:0] width,
  input  logic [ldn_pkg::CFG_W-1:0] height,
  input  logic                     room,
  output logic                     job_push,
  output ldn_pkg::job_t            job_data
);
  import ldn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRD  = 3'd1;
  localparam logic [2:0] S_PEX  = 3'd2;
  localparam logic [2:0] S_E1   = 3'd3;
  localparam logic [2:0] S_E2   = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;

  logic [2:0]             state;
  logic [CFG_W-1:0]       row_count, col_count, drain_col;
  logic                   draining;
  logic [2:0][2:0][PIX_W-1:0] win;
  logic [PIX_W-1:0]       x;
  logic [CFG_W-1:0]       r;
  logic [ADDR_W-1:0]      c;
  logic                   emit2;
  logic [1:0]             fk;
  logic [ADDR_W-1:0]      fd;
  logic [1:0][PIX_W-1:0]  top_buf, mid_buf;

  logic [ADDR_W-1:0] raddr, fc0, fc2;
  logic [PIX_W-1:0]  up_rd, mid_rd, mid_v, top_v;
  logic [2:0][PIX_W-1:0] vrow;
  logic              accept, last_col, last_row, e1, e2, fend, up_we, mid_we;

  assign full   = (state != S_IDLE) || !room;
  assign accept = push && !full;

  assign fc0  = (fd == '0) ? fd : fd - 1'b1;
  assign fend = ({1'b0, fd} + 11'd1) >= width;
  assign fc2  = fend ? fd : fd + 1'b1;

  always_comb begin
    case (state)
      S_PRD:   raddr = c;
      S_FRD: begin
        case (fk)
          2'd0:    raddr = fc0;
          2'd1:    raddr = fd;
          default: raddr = fc2;
        endcase
      end
      default: raddr = c;
    endcase
  end

  assign mid_v    = (r != '0) ? mid_rd : '0;
  assign top_v    = (r > 11'd1) ? up_rd : mid_v;
  assign vrow     = {x, mid_v, top_v};
  assign last_col = ({1'b0, c} + 11'd1) >= width;
  assign last_row = ({1'b0, r} + 12'd1) >= {1'b0, height};
  assign e1       = (r != '0) && (c != '0);
  assign e2       = (r != '0) && last_col;
  assign up_we    = (state == S_PEX) && (r != '0);
  assign mid_we   = (state == S_PEX);

  ldn_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(up_we), .waddr(c), .wdata(mid_rd), .raddr(raddr), .rdata(up_rd)
  );

  ldn_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(mid_we), .waddr(c), .wdata(x), .raddr(raddr), .rdata(mid_rd)
  );

  // Build the request for the back end.
  always_comb begin
    job_push = 1'b0;
    job_data = '0;
    case (state)
      S_E1: begin
        job_push = 1'b1;
        for (int i = 0; i < 3; i++) begin
          job_data.win[i*3]     = win[i][0];
          job_data.win[i*3 + 1] = win[i][1];
          job_data.win[i*3 + 2] = win[i][2];
        end
        job_data.last = !emit2;
      end
      S_E2: begin
        job_push = 1'b1;
        for (int i = 0; i < 3; i++) begin
          job_data.win[i*3]     = win[i][1];
          job_data.win[i*3 + 1] = win[i][2];
          job_data.win[i*3 + 2] = win[i][2];
        end
        job_data.last = 1'b1;
      end
      S_FRD: begin
        job_push = (fk == 2'd3);
        job_data.win[0] = top_buf[0];
        job_data.win[1] = top_buf[1];
        job_data.win[2] = (height > 11'd1) ? up_rd : mid_rd;
        job_data.win[3] = mid_buf[0];
        job_data.win[4] = mid_buf[1];
        job_data.win[5] = mid_rd;
        job_data.win[6] = mid_buf[0];
        job_data.win[7] = mid_buf[1];
        job_data.win[8] = mid_rd;
        job_data.last   = 1'b1;
        job_data.eof    = fend;
      end
      default: job_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_count <= '0;
      col_count <= '0;
      draining  <= 1'b0;
      drain_col <= '0;
      win       <= '0;
      fk        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.action == ACTION_FLUSH) begin
              if (draining) begin
                fd    <= drain_col[ADDR_W-1:0];
                fk    <= '0;
                state <= S_FRD;
              end
            end else begin
              x <= in_data.pixel_value;
              if (draining) begin
                // drop the pending drain; start a new frame
                draining  <= 1'b0;
                drain_col <= '0;
                r         <= '0;
                c         <= '0;
              end else begin
                r <= row_count;
                c <= col_count[ADDR_W-1:0];
              end
              state <= S_PRD;
            end
          end
        end
        S_PRD: state <= S_PEX;
        S_PEX: begin
          for (int i = 0; i < 3; i++) begin
            if (c == '0) begin
              win[i][0] <= vrow[i];
              win[i][1] <= vrow[i];
            end else begin
              win[i][0] <= win[i][1];
              win[i][1] <= win[i][2];
            end
            win[i][2] <= vrow[i];
          end
          emit2 <= e2;
          if (last_col) begin
            col_count <= '0;
            if (last_row) begin
              row_count <= '0;
              draining  <= 1'b1;
              drain_col <= '0;
            end else begin
              row_count <= r + 11'd1;
            end
          end else begin
            col_count <= {1'b0, c} + 11'd1;
          end
          state <= e1 ? S_E1 : (e2 ? S_E2 : S_IDLE);
        end
        S_E1: state <= emit2 ? S_E2 : S_IDLE;
        S_E2: state <= S_IDLE;
        S_FRD: begin
          if (fk != 2'd0 && fk != 2'd3) begin
            top_buf[fk[1]] <= (height > 11'd1) ? up_rd : mid_rd;
            mid_buf[fk[1]] <= mid_rd;
          end
          fk <= fk + 2'd1;
          if (fk == 2'd3) begin
            if (fend) begin
              draining  <= 1'b0;
              drain_col <= '0;
            end else begin
              drain_col <= {1'b0, fd} + 11'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/ldn_jobq.sv
// Short request queue between front and back end.
module ldn_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ldn_pkg::job_t push_data,
  output logic          room,
  input  logic          pop,
  output logic          valid,
  output ldn_pkg::job_t pop_data
);
  import ldn_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0]   count;

  assign valid    = (count != '0);
  assign room     = (count <= (QPTR_W+1)'(QDEPTH - 2));
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < (QPTR_W+1)'(QDEPTH) || pop))
    else $error("request queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("request queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("request queue count mismatch");
`endif

endmodule

### rtl/core/ldn_back.sv
// Back end: window sums, iterative square root and divide, saturation, result register.
module ldn_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  ldn_pkg::job_t      job_data,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output ldn_pkg::out_item_t out_data
);
  import ldn_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_ACC  = 3'd1;
  localparam logic [2:0] B_PREP = 3'd2;
  localparam logic [2:0] B_SQRT = 3'd3;
  localparam logic [2:0] B_DEN  = 3'd4;
  localparam logic [2:0] B_NUM  = 3'd5;
  localparam logic [2:0] B_DIV  = 3'd6;
  localparam logic [2:0] B_DONE = 3'd7;

  logic [2:0]         state;
  job_t               job;
  logic [3:0]         k;
  logic [31:0]        prod;
  logic signed [19:0] s_acc;
  logic [33:0]        q_acc;
  logic [19:0]        mag;
  logic               neg;
  logic [59:0]        rad;
  logic [31:0]        srem;
  logic [29:0]        root;
  logic [5:0]         step;
  logic [33:0]        den;
  logic [44:0]        num;
  logic [33:0]        drem;
  logic [44:0]        quo;
  logic               out_valid;

  logic [3:0]         kidx;
  logic signed [15:0] vk, center;
  logic signed [31:0] sq;
  logic signed [20:0] d;
  logic [33:0]        srem_t, trial;
  logic [34:0]        drem_t;
  logic [44:0]        res;
  logic [15:0]        sat;

  assign kidx   = (k < 4'd9) ? k : 4'd0;
  assign vk     = job.win[kidx];
  assign sq     = vk * vk;
  assign center = job.win[4];
  assign d      = (21'(center) <<< 3) + 21'(center) - 21'(s_acc);
  assign srem_t = {srem, rad[59:58]};
  assign trial  = {2'b00, root, 2'b01};
  assign drem_t = {drem, num[44]};
  assign job_pop = (state == B_IDLE) && job_valid;
  assign empty   = !out_valid;

  always_comb begin
    res = quo;
    if (neg) begin
      if (res > 45'd32768) begin
        res = 45'd32768;
      end
      sat = 16'd0 - res[15:0];
    end else begin
      if (res > 45'd32767) begin
        res = 45'd32767;
      end
      sat = res[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            job   <= job_data;
            k     <= '0;
            s_acc <= '0;
            q_acc <= '0;
            state <= B_ACC;
          end
        end
        B_ACC: begin
          // square now, accumulate the previous square
          if (k < 4'd9) begin
            prod  <= 32'(sq);
            s_acc <= s_acc + 20'(vk);
          end
          if (k != 4'd0) begin
            q_acc <= q_acc + 34'(prod);
          end
          k <= k + 4'd1;
          if (k == 4'd9) begin
            state <= B_PREP;
          end
        end
        B_PREP: begin
          neg <= d[20];
          mag <= d[20] ? 20'(-d) : d[19:0];
          if (q_acc > 34'd65536) begin
            rad   <= {2'b00, q_acc, 24'd0};
            srem  <= '0;
            root  <= '0;
            step  <= '0;
            state <= B_SQRT;
          end else begin
            root  <= 30'd1 << 20;
            state <= B_DEN;
          end
        end
        B_SQRT: begin
          if (srem_t >= trial) begin
            srem <= 32'(srem_t - trial);
            root <= {root[28:0], 1'b1};
          end else begin
            srem <= srem_t[31:0];
            root <= {root[28:0], 1'b0};
          end
          rad  <= rad << 2;
          step <= step + 6'd1;
          if (step == 6'd29) begin
            state <= B_DEN;
          end
        end
        B_DEN: begin
          den   <= (34'(root) << 3) + 34'(root);
          state <= B_NUM;
        end
        B_NUM: begin
          num   <= {1'b0, mag, 24'd0} + 45'(den >> 1);
          drem  <= '0;
          quo   <= '0;
          step  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          if (drem_t >= {1'b0, den}) begin
            drem <= 34'(drem_t - {1'b0, den});
            quo  <= {quo[43:0], 1'b1};
          end else begin
            drem <= drem_t[33:0];
            quo  <= {quo[43:0], 1'b0};
          end
          num  <= num << 1;
          step <= step + 6'd1;
          if (step == 6'd44) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (!out_valid) begin
            out_valid                 <= 1'b1;
            out_data.normalized_value <= sat;
            out_data.last_of_run      <= job.last;
            out_data.end_of_frame     <= job.eof;
            state                     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/local_divisive_normalize_3x3.sv
// Top level of the 3x3 local divisive normalizer.
// Front end: a pixel passes read, execute and one emit state per result; a flush emits one.
// Results trail the pixels by one row plus one pixel.
// Each result: 10 sums, 30 root steps, 45 divide steps in the back end; no root steps at norm <= 1.
// The iterative root and divide units set the rate; the back end takes one request at a time.
// Synchronous active-high reset: counters, window and queues clear; sizes return to 1024.
// Line stores are not cleared; a frame writes every entry before reading it.
module local_divisive_normalize_3x3 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  ldn_pkg::in_item_t         in_data,
  output logic                      empty,
  input  logic                      pop,
  output ldn_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ldn_pkg::IDX_W-1:0] cfg_index,
  input  logic [ldn_pkg::CFG_W-1:0] cfg_data
);
  import ldn_pkg::*;

  logic [CFG_W-1:0] image_width, image_height, eff_w, eff_h;
  logic             room, job_push, job_valid, job_pop;
  job_t             job_in, job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w = (image_width == '0) ? 11'd1 :
                 ((image_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width);
  assign eff_h = (image_height == '0) ? 11'd1 : image_height;

  ldn_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .width(eff_w), .height(eff_h), .room(room),
    .job_push(job_push), .job_data(job_in)
  );

  ldn_jobq u_jobq (
    .clk(clk), .rst(rst), .push(job_push), .push_data(job_in), .room(room),
    .pop(job_pop), .valid(job_valid), .pop_data(job_out)
  );

  ldn_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_data(job_out), .job_pop(job_pop),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

endmodule
